// ===== hdl/i2c_sensor_transaction_master_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef I2C_SENSOR_TRANSACTION_MASTER_MACROS_SVH
`define I2C_SENSOR_TRANSACTION_MASTER_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define I2CSTM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that holds during reset too.
`define I2CSTM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/i2cstm_pkg.sv =====
`default_nettype none
package i2cstm_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_TX_LOW   = 4'd3,
    PH_TX_HIGH  = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_ACK_HOLD = 4'd7,
    PH_RX_LOW   = 4'd8,
    PH_RX_HIGH  = 4'd9,
    PH_MACK_LOW = 4'd10,
    PH_MACK_HI  = 4'd11,
    PH_STOP_A   = 4'd12,
    PH_STOP_B   = 4'd13,
    PH_STOP_C   = 4'd14
  } phase_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HALF_PERIOD    = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd2;

  // Register reset values
  localparam logic [7:0] HALF_PERIOD_RST    = 8'd2;
  localparam logic [9:0] ACK_TIMEOUT_RST    = 10'd100;
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd35;

  // Last bit position of the second received byte
  localparam logic [3:0] LAST_RX_BIT  = 4'd15;
  localparam logic [3:0] FIRST_BYTE_END = 4'd7;

  // Sequencer state
  typedef struct packed {
    phase_t      phase;
    logic [9:0]  tick;
    logic [3:0]  bit_idx;
    logic [7:0]  shift;
    logic [15:0] meas;
    logic        act_op;
    logic        nack;
    logic [7:0]  cmd;
    logic        stage;
    logic [15:0] rx;
  } seq_state_t;

  // Bus levels and status for one tick
  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy;
    logic done;
  } line_t;

endpackage
`default_nettype wire

// ===== hdl/i2c_sensor_transaction_master.sv =====
// Bit-level bus master for a two-byte light sensor.
// Each input transaction is one sequencer tick: a start request with the
// operation (0 send command byte, 1 read two-byte measurement), the command
// byte, and the sampled data line level. Each accepted input produces
// exactly one result transaction carrying the clock and data line levels
// for that tick, the busy and done flags, the last measurement and the
// command acknowledge flag.
// The result is registered and presented in the cycle after the input is accepted.
// Throughput: one transaction per cycle; the whole tick is computed in one
// pass of the sequencer logic into the result register.
// When the receiver stalls, the result register holds and in_ready stays
// low until the result is taken; in_ready is high whenever the result
// register is empty or being emptied in the same cycle.
// Configuration writes (half period, acknowledge timeout, device address)
// take effect at once; the user must make them while the block is idle.
// The block does not enforce this. Synchronous reset returns the sequencer
// to idle, clears the measurement and the acknowledge flag, empties the
// result register and restores the register reset values.
`default_nettype none
`include "i2c_sensor_transaction_master_macros.svh"
module i2c_sensor_transaction_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_request,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_command,
  input  wire logic        in_sda_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl,
  output logic             out_sda_out,
  output logic             out_sda_drive,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [15:0]      out_read_value,
  output logic             out_command_nack
);

  logic [7:0]             half_period_r;
  logic [9:0]             ack_timeout_r;
  logic [6:0]             device_address_r;
  i2cstm_pkg::seq_state_t st_r;
  i2cstm_pkg::seq_state_t st_nxt;
  i2cstm_pkg::line_t      lines_nxt;
  i2cstm_pkg::line_t      lines_r;
  logic [15:0]            read_value_r;
  logic                   nack_r;
  logic                   out_valid_r;
  logic                   in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r    <= i2cstm_pkg::HALF_PERIOD_RST;
      ack_timeout_r    <= i2cstm_pkg::ACK_TIMEOUT_RST;
      device_address_r <= i2cstm_pkg::DEVICE_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cstm_pkg::REG_HALF_PERIOD:    half_period_r    <= cfg_wdata[7:0];
        i2cstm_pkg::REG_ACK_TIMEOUT:    ack_timeout_r    <= cfg_wdata;
        i2cstm_pkg::REG_DEVICE_ADDRESS: device_address_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer logic for one tick
  i2cstm_step u_step (
    .half_period    (half_period_r),
    .ack_timeout    (ack_timeout_r),
    .device_address (device_address_r),
    .st             (st_r),
    .start_request  (in_start_request),
    .operation      (in_operation),
    .command        (in_command),
    .sda_in         (in_sda_in),
    .nxt            (st_nxt),
    .lines          (lines_nxt)
  );

  // Sequencer state advances once per accepted transaction; all-zero is idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lines_r      <= lines_nxt;
      read_value_r <= st_nxt.meas;
      nack_r       <= st_nxt.nack;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl          = lines_r.scl;
  assign out_sda_out      = lines_r.sda_out;
  assign out_sda_drive    = lines_r.sda_drive;
  assign out_busy_res     = lines_r.busy;
  assign out_done_res     = lines_r.done;
  assign out_read_value   = read_value_r;
  assign out_command_nack = nack_r;

  // Checks
  `I2CSTM_ASSERT_CLK(a_state_holds, clk, rst_n, !in_acc |=> $stable(st_r), "sequencer state moved without a transaction")
  `I2CSTM_ASSERT_CLK(a_stop_to_idle, clk, rst_n, (in_acc && st_r.phase == i2cstm_pkg::PH_STOP_C) |=> (st_r.phase == i2cstm_pkg::PH_IDLE && st_r.tick == 10'd0), "stop did not return to idle")
  `I2CSTM_ASSERT_CLK(a_done_not_busy, clk, rst_n, (out_valid_r && lines_r.done) |-> (!lines_r.busy && lines_r.sda_drive && lines_r.scl), "completion tick flagged busy")

endmodule
`default_nettype wire

// ===== hdl/i2cstm_step.sv =====
`default_nettype none
// One tick of the bus sequencer: next state and line levels.
module i2cstm_step (
  input  wire logic [7:0]              half_period,
  input  wire logic [9:0]              ack_timeout,
  input  wire logic [6:0]              device_address,
  input  wire i2cstm_pkg::seq_state_t  st,
  input  wire logic                    start_request,
  input  wire logic                    operation,
  input  wire logic [7:0]              command,
  input  wire logic                    sda_in,
  output i2cstm_pkg::seq_state_t       nxt,
  output i2cstm_pkg::line_t            lines
);

  i2cstm_pkg::phase_t ph;
  logic [9:0]         tc_inc;
  logic               half_hit;
  logic [9:0]         half_tick;
  logic [9:0]         to_lim;
  logic               mack_level;

  always_comb begin
    nxt = st;
    lines.scl       = 1'b1;
    lines.sda_out   = 1'b1;
    lines.sda_drive = 1'b0;
    lines.done      = 1'b0;

    // Request taken only when idle; acts as the first start tick
    if (st.phase == i2cstm_pkg::PH_IDLE && start_request) begin
      nxt.act_op = operation;
      nxt.cmd    = command;
      if (!operation) begin
        nxt.nack = 1'b0;
      end
      nxt.phase = i2cstm_pkg::PH_START_A;
      nxt.tick  = '0;
    end

    ph         = nxt.phase;
    tc_inc     = nxt.tick + 10'd1;
    half_hit   = (tc_inc >= {2'b00, half_period});
    half_tick  = half_hit ? 10'd0 : tc_inc;
    to_lim     = (ack_timeout == 10'd0) ? 10'd1 : ack_timeout;
    mack_level = (nxt.bit_idx == i2cstm_pkg::LAST_RX_BIT);

    // Line levels for this tick
    unique case (ph)
      i2cstm_pkg::PH_START_A: lines.sda_drive = 1'b1;
      i2cstm_pkg::PH_START_B: begin
        lines.sda_drive = 1'b1;
        lines.sda_out   = 1'b0;
      end
      i2cstm_pkg::PH_TX_LOW: begin
        lines.scl       = 1'b0;
        lines.sda_drive = 1'b1;
        lines.sda_out   = nxt.shift[7];
      end
      i2cstm_pkg::PH_TX_HIGH: begin
        lines.sda_drive = 1'b1;
        lines.sda_out   = nxt.shift[7];
      end
      i2cstm_pkg::PH_ACK_LOW, i2cstm_pkg::PH_RX_LOW: lines.scl = 1'b0;
      i2cstm_pkg::PH_MACK_LOW: begin
        lines.scl       = 1'b0;
        lines.sda_drive = 1'b1;
        lines.sda_out   = mack_level;
      end
      i2cstm_pkg::PH_MACK_HI: begin
        lines.sda_drive = 1'b1;
        lines.sda_out   = mack_level;
      end
      i2cstm_pkg::PH_STOP_A: begin
        lines.scl       = 1'b0;
        lines.sda_drive = 1'b1;
        lines.sda_out   = 1'b0;
      end
      i2cstm_pkg::PH_STOP_B: begin
        lines.sda_drive = 1'b1;
        lines.sda_out   = 1'b0;
      end
      i2cstm_pkg::PH_STOP_C: begin
        lines.sda_drive = 1'b1;
        lines.done      = 1'b1;
      end
      default: ;
    endcase

    // Phase transitions
    unique case (ph)
      i2cstm_pkg::PH_START_A: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_START_B;
      end
      i2cstm_pkg::PH_START_B: begin
        nxt.tick = half_tick;
        if (half_hit) begin
          nxt.phase   = i2cstm_pkg::PH_TX_LOW;
          nxt.bit_idx = '0;
          nxt.shift   = {device_address, nxt.act_op};
          nxt.stage   = 1'b0;
        end
      end
      i2cstm_pkg::PH_TX_LOW: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_TX_HIGH;
      end
      i2cstm_pkg::PH_TX_HIGH: begin
        nxt.tick = half_tick;
        if (half_hit) begin
          nxt.shift = {nxt.shift[6:0], 1'b0};
          if (nxt.bit_idx >= 4'd7) begin
            nxt.bit_idx = '0;
            nxt.phase   = i2cstm_pkg::PH_ACK_LOW;
          end else begin
            nxt.bit_idx = nxt.bit_idx + 4'd1;
            nxt.phase   = i2cstm_pkg::PH_TX_LOW;
          end
        end
      end
      i2cstm_pkg::PH_ACK_LOW: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_ACK_HIGH;
      end
      i2cstm_pkg::PH_ACK_HIGH: begin
        if (!sda_in) begin
          nxt.tick  = '0;
          nxt.phase = i2cstm_pkg::PH_ACK_HOLD;
        end else if (tc_inc >= to_lim) begin
          // acknowledge timed out
          nxt.tick = '0;
          if (nxt.act_op) begin
            nxt.phase   = i2cstm_pkg::PH_RX_LOW;
            nxt.bit_idx = '0;
            nxt.rx      = '0;
          end else if (!nxt.stage) begin
            nxt.phase = i2cstm_pkg::PH_START_A;
          end else begin
            nxt.nack  = 1'b1;
            nxt.phase = i2cstm_pkg::PH_STOP_A;
          end
        end else begin
          nxt.tick = tc_inc;
        end
      end
      i2cstm_pkg::PH_ACK_HOLD: begin
        nxt.tick = half_tick;
        if (half_hit) begin
          if (nxt.act_op) begin
            nxt.phase   = i2cstm_pkg::PH_RX_LOW;
            nxt.bit_idx = '0;
            nxt.rx      = '0;
          end else if (!nxt.stage) begin
            nxt.stage   = 1'b1;
            nxt.bit_idx = '0;
            nxt.shift   = nxt.cmd;
            nxt.phase   = i2cstm_pkg::PH_TX_LOW;
          end else begin
            nxt.nack  = 1'b0;
            nxt.phase = i2cstm_pkg::PH_STOP_A;
          end
        end
      end
      i2cstm_pkg::PH_RX_LOW: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_RX_HIGH;
      end
      i2cstm_pkg::PH_RX_HIGH: begin
        // sample on the first tick of the high half
        if (nxt.tick == 10'd0) nxt.rx = {nxt.rx[14:0], sda_in};
        nxt.tick = half_tick;
        if (half_hit) begin
          if (nxt.bit_idx[2:0] == 3'd7) begin
            nxt.phase = i2cstm_pkg::PH_MACK_LOW;
          end else begin
            nxt.bit_idx = nxt.bit_idx + 4'd1;
            nxt.phase   = i2cstm_pkg::PH_RX_LOW;
          end
        end
      end
      i2cstm_pkg::PH_MACK_LOW: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_MACK_HI;
      end
      i2cstm_pkg::PH_MACK_HI: begin
        nxt.tick = half_tick;
        if (half_hit) begin
          if (nxt.bit_idx == i2cstm_pkg::FIRST_BYTE_END) begin
            nxt.bit_idx = 4'd8;
            nxt.phase   = i2cstm_pkg::PH_RX_LOW;
          end else begin
            nxt.meas  = nxt.rx;
            nxt.phase = i2cstm_pkg::PH_STOP_A;
          end
        end
      end
      i2cstm_pkg::PH_STOP_A: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_STOP_B;
      end
      i2cstm_pkg::PH_STOP_B: begin
        nxt.tick = half_tick;
        if (half_hit) nxt.phase = i2cstm_pkg::PH_STOP_C;
      end
      default: begin
        nxt.tick  = '0;
        nxt.phase = i2cstm_pkg::PH_IDLE;
      end
    endcase

    lines.busy = !lines.done &&
                 (!lines.scl || !lines.sda_out || lines.sda_drive ||
                  nxt.phase != i2cstm_pkg::PH_IDLE || nxt.tick != 10'd0);
  end

endmodule
`default_nettype wire

// ===== tb/tb_i2c_sensor_transaction_master.sv =====
`timescale 1ns / 1ps

module tb_i2c_sensor_transaction_master;

  // one sequencer tick as driven on the input channel
  typedef struct packed {
    logic       start;
    logic       op;
    logic [7:0] cmd;
    logic       sda;
  } tick_item_t;

  // bus levels and status for one tick
  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy;
    logic        done;
    logic [15:0] value;
    logic        nack;
  } bus_line_t;

  // sequencer state of the predictor
  typedef struct packed {
    i2cstm_pkg::phase_t phase;
    logic [9:0]         tick;
    logic [3:0]         bit_no;
    logic [7:0]         shift;
    logic [15:0]        meas;
    logic               op;
    logic               nack;
    logic [7:0]         cmd;
    logic               stage;
    logic [15:0]        rx;
  } seq_model_t;

  typedef struct packed {
    logic [7:0] half_ticks;
    logic [9:0] ack_limit;
    logic [6:0] dev_addr;
  } reg_file_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_start_request = 1'b0;
  logic        in_operation = 1'b0;
  logic [7:0]  in_command = '0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [15:0] out_read_value;
  logic        out_command_nack;

  i2c_sensor_transaction_master uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_request (in_start_request),
    .in_operation     (in_operation),
    .in_command       (in_command),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl          (out_scl),
    .out_sda_out      (out_sda_out),
    .out_sda_drive    (out_sda_drive),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_value   (out_read_value),
    .out_command_nack (out_command_nack)
  );

  initial forever #6 clk = ~clk;

  // predictor state: regs, the planner's look-ahead copy, the copy tracking the DUT
  reg_file_t  regs;
  seq_model_t plan_seq;
  seq_model_t seq_now;

  tick_item_t pending_ticks[$];
  bus_line_t  expected_lines[$];

  tick_item_t cur_tick;
  bus_line_t  line_want;
  logic       in_fire;
  int         planned = 0;
  int         sent_count = 0;
  int         got_count = 0;
  int         gap_left = 0;
  int         gap_max = 8;
  int         stall_left = 0;
  int         stall_max = 8;
  int         fail_count = 0;

  // advance the half-phase counter; true when the half is over
  function automatic logic half_done(inout seq_model_t m, input logic [7:0] hp);
    m.tick = m.tick + 10'd1;
    if (m.tick >= {2'b00, hp}) begin
      m.tick = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one bus tick: line levels for this tick, then the phase advance
  function automatic bus_line_t sequencer_tick(inout seq_model_t m, input reg_file_t r,
                                               input tick_item_t t);
    bus_line_t  o;
    logic [9:0] limit;
    o = '0;
    o.scl = 1'b1;
    o.sda_out = 1'b1;
    limit = (r.ack_limit == '0) ? 10'd1 : r.ack_limit;

    // a request only counts when idle and starts on this very tick
    if (m.phase == i2cstm_pkg::PH_IDLE && t.start) begin
      m.op = t.op;
      m.cmd = t.cmd;
      if (!t.op) m.nack = 1'b0;
      m.phase = i2cstm_pkg::PH_START_A;
      m.tick = '0;
    end

    case (m.phase)
      i2cstm_pkg::PH_START_A: o.sda_drive = 1'b1;
      i2cstm_pkg::PH_START_B: begin
        o.sda_drive = 1'b1;
        o.sda_out = 1'b0;
      end
      i2cstm_pkg::PH_TX_LOW: begin
        o.scl = 1'b0;
        o.sda_drive = 1'b1;
        o.sda_out = m.shift[7];
      end
      i2cstm_pkg::PH_TX_HIGH: begin
        o.sda_drive = 1'b1;
        o.sda_out = m.shift[7];
      end
      i2cstm_pkg::PH_ACK_LOW, i2cstm_pkg::PH_RX_LOW: o.scl = 1'b0;
      i2cstm_pkg::PH_MACK_LOW: begin
        o.scl = 1'b0;
        o.sda_drive = 1'b1;
        o.sda_out = (m.bit_no == i2cstm_pkg::LAST_RX_BIT);
      end
      i2cstm_pkg::PH_MACK_HI: begin
        o.sda_drive = 1'b1;
        o.sda_out = (m.bit_no == i2cstm_pkg::LAST_RX_BIT);
      end
      i2cstm_pkg::PH_STOP_A: begin
        o.scl = 1'b0;
        o.sda_drive = 1'b1;
        o.sda_out = 1'b0;
      end
      i2cstm_pkg::PH_STOP_B: begin
        o.sda_drive = 1'b1;
        o.sda_out = 1'b0;
      end
      i2cstm_pkg::PH_STOP_C: begin
        o.sda_drive = 1'b1;
        o.done = 1'b1;
      end
      default: ;
    endcase

    case (m.phase)
      i2cstm_pkg::PH_START_A: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_START_B;
      end
      i2cstm_pkg::PH_START_B: if (half_done(m, r.half_ticks)) begin
        // address byte with the r/w bit appended
        m.phase = i2cstm_pkg::PH_TX_LOW;
        m.bit_no = '0;
        m.shift = {r.dev_addr, m.op};
        m.stage = 1'b0;
      end
      i2cstm_pkg::PH_TX_LOW: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_TX_HIGH;
      end
      i2cstm_pkg::PH_TX_HIGH: if (half_done(m, r.half_ticks)) begin
        m.shift = {m.shift[6:0], 1'b0};
        if (m.bit_no >= i2cstm_pkg::FIRST_BYTE_END) begin
          m.bit_no = '0;
          m.phase = i2cstm_pkg::PH_ACK_LOW;
        end else begin
          m.bit_no = m.bit_no + 4'd1;
          m.phase = i2cstm_pkg::PH_TX_LOW;
        end
      end
      i2cstm_pkg::PH_ACK_LOW: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_ACK_HIGH;
      end
      i2cstm_pkg::PH_ACK_HIGH: begin
        if (!t.sda) begin
          m.tick = '0;
          m.phase = i2cstm_pkg::PH_ACK_HOLD;
        end else begin
          m.tick = m.tick + 10'd1;
          // timed out: reads go on, sends retry address or flag the command
          if (m.tick >= limit) begin
            m.tick = '0;
            if (m.op) begin
              m.phase = i2cstm_pkg::PH_RX_LOW;
              m.bit_no = '0;
              m.rx = '0;
            end else if (!m.stage) begin
              m.phase = i2cstm_pkg::PH_START_A;
            end else begin
              m.nack = 1'b1;
              m.phase = i2cstm_pkg::PH_STOP_A;
            end
          end
        end
      end
      i2cstm_pkg::PH_ACK_HOLD: if (half_done(m, r.half_ticks)) begin
        if (m.op) begin
          m.phase = i2cstm_pkg::PH_RX_LOW;
          m.bit_no = '0;
          m.rx = '0;
        end else if (!m.stage) begin
          m.stage = 1'b1;
          m.bit_no = '0;
          m.shift = m.cmd;
          m.phase = i2cstm_pkg::PH_TX_LOW;
        end else begin
          m.nack = 1'b0;
          m.phase = i2cstm_pkg::PH_STOP_A;
        end
      end
      i2cstm_pkg::PH_RX_LOW: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_RX_HIGH;
      end
      i2cstm_pkg::PH_RX_HIGH: begin
        // sample on the first tick of the high half
        if (m.tick == '0) m.rx = {m.rx[14:0], t.sda};
        if (half_done(m, r.half_ticks)) begin
          if (m.bit_no[2:0] == i2cstm_pkg::FIRST_BYTE_END[2:0]) begin
            m.phase = i2cstm_pkg::PH_MACK_LOW;
          end else begin
            m.bit_no = m.bit_no + 4'd1;
            m.phase = i2cstm_pkg::PH_RX_LOW;
          end
        end
      end
      i2cstm_pkg::PH_MACK_LOW: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_MACK_HI;
      end
      i2cstm_pkg::PH_MACK_HI: if (half_done(m, r.half_ticks)) begin
        if (m.bit_no == i2cstm_pkg::FIRST_BYTE_END) begin
          m.bit_no = 4'd8;
          m.phase = i2cstm_pkg::PH_RX_LOW;
        end else begin
          m.meas = m.rx;
          m.phase = i2cstm_pkg::PH_STOP_A;
        end
      end
      i2cstm_pkg::PH_STOP_A: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_STOP_B;
      end
      i2cstm_pkg::PH_STOP_B: begin
        if (half_done(m, r.half_ticks)) m.phase = i2cstm_pkg::PH_STOP_C;
      end
      default: begin
        m.tick = '0;
        m.phase = i2cstm_pkg::PH_IDLE;
      end
    endcase

    o.busy = !o.done && (!o.scl || !o.sda_out || o.sda_drive ||
                         m.phase != i2cstm_pkg::PH_IDLE || m.tick != '0);
    o.value = m.meas;
    o.nack = m.nack;
    return o;
  endfunction

  // queue one tick and run it through the look-ahead copy
  task automatic plan_tick(input logic req, input logic op, input logic [7:0] cmd,
                           input logic sda);
    tick_item_t t;
    bus_line_t  unused;
    t.start = req;
    t.op = op;
    t.cmd = cmd;
    t.sda = sda;
    unused = sequencer_tick(plan_seq, regs, t);
    pending_ticks.push_back(t);
    planned++;
  endtask

  // idle ticks with no request; the other fields are noise
  task automatic idle_ticks(input int n);
    for (int i = 0; i < n; i++)
      plan_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  // one whole bus transaction with a slave that acks, stays silent, or returns data
  task automatic run_txn(input logic op, input logic [7:0] cmd, input logic [15:0] data,
                         input int addr_nacks, input logic rd_nack, input logic cmd_nack);
    int                 nacks_left;
    int                 eff_limit;
    int                 ack_wait;
    int                 ack_ticks;
    logic               ack_miss;
    logic               req;
    logic               sda;
    i2cstm_pkg::phase_t prev;
    nacks_left = addr_nacks;
    ack_wait = 0;
    ack_ticks = 0;
    ack_miss = 1'b0;
    prev = i2cstm_pkg::PH_IDLE;
    plan_tick(1'b1, op, cmd, 1'($urandom_range(0, 1)));
    while (plan_seq.phase != i2cstm_pkg::PH_IDLE) begin
      // requests while busy are ignored, the completion tick included
      req = (plan_seq.phase == i2cstm_pkg::PH_STOP_C) ? 1'($urandom_range(0, 1))
                                                      : ($urandom_range(0, 3) == 0);
      sda = 1'($urandom_range(0, 1));
      case (plan_seq.phase)
        i2cstm_pkg::PH_ACK_HIGH: begin
          if (prev != i2cstm_pkg::PH_ACK_HIGH) begin
            eff_limit = (regs.ack_limit == '0) ? 1 : int'(regs.ack_limit);
            ack_wait = $urandom_range(0, (eff_limit - 1 < 3) ? eff_limit - 1 : 3);
            ack_ticks = 0;
            if (plan_seq.stage) begin
              ack_miss = cmd_nack;
            end else if (op) begin
              ack_miss = rd_nack;
            end else begin
              ack_miss = (nacks_left > 0);
              if (nacks_left > 0) nacks_left--;
            end
          end
          sda = ack_miss || (ack_ticks < ack_wait);
          ack_ticks++;
        end
        i2cstm_pkg::PH_RX_HIGH: begin
          if (plan_seq.tick == '0) sda = data[4'd15 - plan_seq.bit_no];
        end
        default: ;
      endcase
      prev = plan_seq.phase;
      plan_tick(req, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), sda);
    end
  endtask

  task automatic run_random_txn();
    run_txn(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
            16'($urandom_range(0, 65535)), ($urandom_range(0, 3) == 0) ? 1 : 0,
            ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0));
  endtask

  // sender pause until every queued transaction has come back
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_lines.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] hp, input logic [9:0] lim, input logic [6:0] addr);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i2cstm_pkg::REG_HALF_PERIOD;
    cfg_wdata <= {2'b00, hp};
    @(posedge clk);
    cfg_index <= i2cstm_pkg::REG_ACK_TIMEOUT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= i2cstm_pkg::REG_DEVICE_ADDRESS;
    cfg_wdata <= {3'b000, addr};
    @(posedge clk);
    cfg_we <= 1'b0;
    regs.half_ticks = hp;
    regs.ack_limit = lim;
    regs.dev_addr = addr;
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      if (fail_count < 100)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // driver: predict on acceptance, then present the next tick after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        line_want = sequencer_tick(seq_now, regs, cur_tick);
        expected_lines.push_back(line_want);
        sent_count++;
        // alternate stretches with gaps and without
        if (sent_count % 150 == 0) gap_max = $urandom_range(0, 1) ? 8 : 0;
        gap_left = $urandom_range(0, gap_max);
      end
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          in_start_request <= cur_tick.start;
          in_operation <= cur_tick.op;
          in_command <= cur_tick.cmd;
          in_sda_in <= cur_tick.sda;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expected tick
  always @(posedge clk) begin : monitor
    bus_line_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          if (fail_count < 100)
            $display("%0t ns: result with nothing expected, expected none, actual scl %0b",
                     $time, out_scl);
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("scl", 16'(want.scl), 16'(out_scl));
          check_field("sda_out", 16'(want.sda_out), 16'(out_sda_out));
          check_field("sda_drive", 16'(want.sda_drive), 16'(out_sda_drive));
          check_field("busy_res", 16'(want.busy), 16'(out_busy_res));
          check_field("done_res", 16'(want.done), 16'(out_done_res));
          check_field("read_value", want.value, out_read_value);
          check_field("command_nack", 16'(want.nack), 16'(out_command_nack));
        end
        got_count++;
        if (got_count % 170 == 0) stall_max = $urandom_range(0, 1) ? 8 : 0;
        // one long hold-off so the result register fills and in_ready drops
        stall_left = (got_count == 400) ? 64 : $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    regs.half_ticks = i2cstm_pkg::HALF_PERIOD_RST;
    regs.ack_limit = i2cstm_pkg::ACK_TIMEOUT_RST;
    regs.dev_addr = i2cstm_pkg::DEVICE_ADDRESS_RST;
    plan_seq = '0;
    plan_seq.phase = i2cstm_pkg::PH_IDLE;
    seq_now = '0;
    seq_now.phase = i2cstm_pkg::PH_IDLE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    idle_ticks(3);
    run_txn(1'b0, 8'h00, 16'h0000, 0, 1'b0, 1'b0);
    run_txn(1'b0, 8'hFF, 16'h0000, 0, 1'b0, 1'b1);
    run_txn(1'b0, 8'hA5, 16'h0000, 1, 1'b0, 1'b0);
    idle_ticks(2);
    run_txn(1'b1, 8'h5A, 16'hFFFF, 0, 1'b0, 1'b0);
    run_txn(1'b1, 8'h3C, 16'h8001, 0, 1'b1, 1'b0);
    drain();

    // shortest phases, address zero
    set_regs(8'd1, 10'd1, 7'd0);
    run_txn(1'b0, 8'h7E, 16'h0000, 0, 1'b0, 1'b0);
    run_txn(1'b0, 8'h01, 16'h0000, 1, 1'b0, 1'b1);
    run_txn(1'b1, 8'h00, 16'h1234, 0, 1'b0, 1'b0);
    drain();

    // zero half period and zero timeout behave as one
    set_regs(8'd0, 10'd0, 7'd127);
    run_txn(1'b0, 8'hE7, 16'h0000, 1, 1'b0, 1'b0);
    run_txn(1'b1, 8'h18, 16'hFFFF, 0, 1'b0, 1'b0);
    drain();

    // longer half period, one send only
    set_regs(8'd4, 10'd1, 7'd85);
    run_txn(1'b0, 8'h3C, 16'h0000, 0, 1'b0, 1'b0);
    drain();

    // random transactions under two random settings
    for (int s = 0; s < 2; s++) begin
      int first;
      set_regs(8'($urandom_range(1, (s == 1) ? 8 : 4)), 10'($urandom_range(1, 40)),
               7'($urandom_range(0, 127)));
      first = planned;
      while (planned - first < 150) begin
        idle_ticks($urandom_range(0, 4));
        run_random_txn();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_lines.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #12_500_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== i2c_sensor_transaction_master.f =====
+incdir+hdl
hdl/i2cstm_pkg.sv
hdl/i2cstm_step.sv
hdl/i2c_sensor_transaction_master.sv
tb/tb_i2c_sensor_transaction_master.sv
